// File: sv/jerk_limited_speed_ramp_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef JERK_LIMITED_SPEED_RAMP_UNIT_MACROS_SVH
`define JERK_LIMITED_SPEED_RAMP_UNIT_MACROS_SVH

// Same-cycle implication.
`define JLSR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jlsr assertion failed");

// Next-cycle implication.
`define JLSR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jlsr assertion failed");

`endif

// File: sv/jlsr_pkg.sv
package jlsr_pkg;

  localparam int LIM_W   = 24;
  localparam int TICK_W  = 16;
  localparam int SPD_W   = 24;
  localparam int ACC_W   = 25;
  localparam int ACCO_W  = 32;
  localparam int DIV_W   = 40;
  localparam int MAG_W   = 25;
  localparam int PROD_W  = DIV_W + MAG_W;
  localparam int SQ_W    = 2 * LIM_W;
  localparam int CNT_W   = 6;

  localparam int JDIV_STEPS = DIV_W;
  localparam int SDIV_STEPS = LIM_W;
  localparam int MUL_STEPS  = MAG_W;
  localparam int SQRT_STEPS = LIM_W;
  localparam int VDIV_STEPS = ACC_W;

  localparam logic [1:0] REG_ACCEL_LIMIT  = 2'd0;
  localparam logic [1:0] REG_DECEL_LIMIT  = 2'd1;
  localparam logic [1:0] REG_RISE_TICKS   = 2'd2;
  localparam logic [1:0] REG_TICK_RATE_HZ = 2'd3;

  localparam logic [LIM_W-1:0]  ACCEL_LIMIT_RST  = 24'd76800;
  localparam logic [LIM_W-1:0]  DECEL_LIMIT_RST  = 24'd76800;
  localparam logic [TICK_W-1:0] RISE_TICKS_RST   = 16'd100;
  localparam logic [TICK_W-1:0] TICK_RATE_HZ_RST = 16'd1000;

  typedef struct packed {
    logic cap;
    logic prep;
    logic div_step;
    logic sload;
    logic mul_step;
    logic sqload;
    logic sq_step;
    logic slew;
    logic vload;
    logic done;
  } jlsr_cmd_t;

endpackage

// File: sv/jlsr_ctrl.sv
module jlsr_ctrl
  import jlsr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  logic      m_tready,
  output logic      m_tvalid,
  output jlsr_cmd_t cmd
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_PREP   = 11'b00000000010,
    S_JDIV   = 11'b00000000100,
    S_SLOAD  = 11'b00000001000,
    S_MULDIV = 11'b00000010000,
    S_SQLOAD = 11'b00000100000,
    S_SQRT   = 11'b00001000000,
    S_SLEW   = 11'b00010000000,
    S_VLOAD  = 11'b00100000000,
    S_VDIV   = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_t;

  state_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    cnt_next = cnt + 1'b1;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cnt_next = '0;
        if (s_tvalid) begin
          cmd.cap = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        cnt_next = '0;
        state_next = S_JDIV;
      end
      S_JDIV: begin
        cmd.div_step = 1'b1;
        if (cnt == CNT_W'(JDIV_STEPS - 1)) state_next = S_SLOAD;
      end
      S_SLOAD: begin
        cmd.sload = 1'b1;
        cnt_next = '0;
        state_next = S_MULDIV;
      end
      S_MULDIV: begin
        // The step division is one bit shorter than the multiply.
        cmd.mul_step = 1'b1;
        cmd.div_step = (cnt < CNT_W'(SDIV_STEPS));
        if (cnt == CNT_W'(MUL_STEPS - 1)) state_next = S_SQLOAD;
      end
      S_SQLOAD: begin
        cmd.sqload = 1'b1;
        cnt_next = '0;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.sq_step = 1'b1;
        if (cnt == CNT_W'(SQRT_STEPS - 1)) state_next = S_SLEW;
      end
      S_SLEW: begin
        cmd.slew = 1'b1;
        state_next = S_VLOAD;
      end
      S_VLOAD: begin
        cmd.vload = 1'b1;
        cnt_next = '0;
        state_next = S_VDIV;
      end
      S_VDIV: begin
        cmd.div_step = 1'b1;
        if (cnt == CNT_W'(VDIV_STEPS - 1)) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.done = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      if (cmd.done) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule

// File: sv/jlsr_dp.sv
module jlsr_dp
  import jlsr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  jlsr_cmd_t                cmd,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [LIM_W-1:0]         cfg_data,
  input  logic signed [SPD_W-1:0]  target_speed,
  input  logic                     restart,
  output logic signed [SPD_W-1:0]  speed_out,
  output logic signed [ACCO_W-1:0] accel_out
);

  logic [LIM_W-1:0]  accel_limit, decel_limit;
  logic [TICK_W-1:0] rise_ticks, tick_rate_hz;
  logic [TICK_W-1:0] rise_eff, rate_eff;

  logic signed [SPD_W-1:0] speed_now, target;
  logic signed [ACC_W-1:0] accel_now;
  logic                    up, cap, neg;
  logic [MAG_W-1:0]        mag;
  logic [LIM_W-1:0]        a_lim, step;
  logic [SQ_W-1:0]         a_sq;

  logic [DIV_W-1:0]  dq;
  logic [TICK_W-1:0] dr, dd;
  logic [PROD_W-1:0] macc, mcand;
  logic [MAG_W-1:0]  mplr;
  logic [SQ_W-1:0]   sx;
  logic [LIM_W+1:0]  srem;
  logic [LIM_W-1:0]  sroot;

  logic signed [SPD_W-1:0] sp_in;
  logic signed [MAG_W-1:0] gap;
  logic [TICK_W:0]         rr;
  logic                    rge;
  logic [PROD_W:0]         prod2;
  logic [LIM_W+1:0]        st, strial;
  logic                    sge;
  logic [LIM_W-1:0]        w;
  logic signed [ACC_W:0]   want, a26, asum, slew_val;
  logic [ACC_W-1:0]        amag;
  logic signed [ACC_W:0]   dv;
  logic signed [SPD_W+2:0] nx;
  logic signed [SPD_W-1:0] sat;
  logic                    over;

  assign rise_eff = (rise_ticks == '0) ? TICK_W'(1) : rise_ticks;
  assign rate_eff = (tick_rate_hz == '0) ? TICK_W'(1) : tick_rate_hz;

  always_comb begin
    sp_in = restart ? '0 : speed_now;
    gap = MAG_W'(target_speed) - MAG_W'(sp_in);
    rr = {dr, dq[DIV_W-1]};
    rge = (rr >= {1'b0, dd});
    prod2 = {macc, 1'b0};
    st = {srem[LIM_W-1:0], sx[SQ_W-1 -: 2]};
    strial = {sroot, 2'b01};
    sge = (st >= strial);
    w = cap ? a_lim : sroot;
    want = up ? (ACC_W+1)'({2'b00, w}) : -(ACC_W+1)'({2'b00, w});
    a26 = (ACC_W+1)'(accel_now);
    slew_val = a26;
    asum = a26;
    if (a26 < want) begin
      asum = a26 + (ACC_W+1)'({2'b00, step});
      slew_val = (asum > want) ? want : asum;
    end else if (a26 > want) begin
      asum = a26 - (ACC_W+1)'({2'b00, step});
      slew_val = (asum < want) ? want : asum;
    end
    amag = accel_now[ACC_W-1] ? ACC_W'(-accel_now) : ACC_W'(accel_now);
    dv = neg ? -(ACC_W+1)'({1'b0, dq[ACC_W-1:0]}) : (ACC_W+1)'({1'b0, dq[ACC_W-1:0]});
    nx = (SPD_W+3)'(speed_now) + (SPD_W+3)'(dv);
    if (nx > (SPD_W+3)'(signed'({1'b0, {(SPD_W-1){1'b1}}}))) sat = {1'b0, {(SPD_W-1){1'b1}}};
    else if (nx < (SPD_W+3)'(signed'({1'b1, {(SPD_W-1){1'b0}}})))
      sat = {1'b1, {(SPD_W-1){1'b0}}};
    else sat = nx[SPD_W-1:0];
    over = up ? (sat > target) : (sat < target);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_limit <= ACCEL_LIMIT_RST;
      decel_limit <= DECEL_LIMIT_RST;
      rise_ticks <= RISE_TICKS_RST;
      tick_rate_hz <= TICK_RATE_HZ_RST;
      speed_now <= '0;
      accel_now <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ACCEL_LIMIT:  accel_limit <= cfg_data;
          REG_DECEL_LIMIT:  decel_limit <= cfg_data;
          REG_RISE_TICKS:   rise_ticks <= cfg_data[TICK_W-1:0];
          REG_TICK_RATE_HZ: tick_rate_hz <= cfg_data[TICK_W-1:0];
          default: ;
        endcase
      end
      if (cmd.cap && restart) begin
        speed_now <= '0;
        accel_now <= '0;
      end
      if (cmd.slew) accel_now <= slew_val[ACC_W-1:0];
      if (cmd.done) begin
        speed_now <= over ? target : sat;
        if (over) accel_now <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      target <= target_speed;
      up <= !gap[MAG_W-1];
      mag <= gap[MAG_W-1] ? MAG_W'(-gap) : MAG_W'(gap);
      a_lim <= gap[MAG_W-1] ? decel_limit : accel_limit;
    end
    if (cmd.prep) begin
      a_sq <= SQ_W'(a_lim) * SQ_W'(a_lim);
      dq <= DIV_W'(a_lim) * DIV_W'(rate_eff);
      dd <= rise_eff;
      dr <= '0;
    end
    if (cmd.div_step) begin
      dr <= rge ? TICK_W'(rr - {1'b0, dd}) : rr[TICK_W-1:0];
      dq <= {dq[DIV_W-2:0], rge};
    end
    if (cmd.sload) begin
      mcand <= PROD_W'(dq);
      mplr <= mag;
      macc <= '0;
      dq <= {a_lim, {(DIV_W-LIM_W){1'b0}}};
      dd <= rise_eff;
      dr <= '0;
    end
    if (cmd.mul_step) begin
      if (mplr[0]) macc <= macc + mcand;
      mcand <= {mcand[PROD_W-2:0], 1'b0};
      mplr <= {1'b0, mplr[MAG_W-1:1]};
    end
    if (cmd.sqload) begin
      step <= dq[LIM_W-1:0];
      cap <= (prod2 >= (PROD_W+1)'(a_sq));
      sx <= prod2[SQ_W-1:0];
      srem <= '0;
      sroot <= '0;
    end
    if (cmd.sq_step) begin
      srem <= sge ? (st - strial) : st;
      sroot <= {sroot[LIM_W-2:0], sge};
      sx <= {sx[SQ_W-3:0], 2'b00};
    end
    if (cmd.vload) begin
      neg <= accel_now[ACC_W-1];
      dq <= {amag + ACC_W'(rate_eff[TICK_W-1:1]), {(DIV_W-ACC_W){1'b0}}};
      dd <= rate_eff;
      dr <= '0;
    end
    if (cmd.done) begin
      speed_out <= over ? target : sat;
      accel_out <= over ? '0 : ACCO_W'(accel_now);
    end
  end

endmodule

// File: sv/jerk_limited_speed_ramp_unit.sv
// Jerk-limited speed ramp. Each input transfer is one control tick carrying a
// target speed and a restart flag; the block answers with one output transfer
// holding the new speed and the applied acceleration. Each item runs through
// one serial restoring divider, and the block takes no new tick until its result is in the output register;
// the divider runs three divisions of
// 40, 24 and 25 bits one bit per cycle, a shift-add multiplier and a
// one-bit-per-cycle square root. A finished result waits in the output
// register while the next tick is accepted. Configuration writes take effect
// at once and must be made while no tick is in flight.
module jerk_limited_speed_ramp_unit
  import jlsr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [LIM_W-1:0] cfg_data,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [23:0]      s_tdata,   // target_speed[23:0]
  input  logic             s_tuser,   // restart
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [55:0]      m_tdata    // speed_out[23:0], accel_out[55:24]
);

  jlsr_cmd_t cmd;
  logic signed [SPD_W-1:0]  speed_out;
  logic signed [ACCO_W-1:0] accel_out;

  jlsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .cmd      (cmd)
  );

  jlsr_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .target_speed (signed'(s_tdata)),
    .restart      (s_tuser),
    .speed_out    (speed_out),
    .accel_out    (accel_out)
  );

  assign m_tdata = {accel_out, speed_out};

endmodule

// File: sv/jlsr_chk.sv
`include "jerk_limited_speed_ramp_unit_macros.svh"

module jlsr_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata
);

  `JLSR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
  `JLSR_ASSERT_NEXT(a_out_data_hold, m_tvalid && !m_tready, $stable(m_tdata))
  `JLSR_ASSERT_NEXT(a_busy_after_in, s_tvalid && s_tready, !s_tready)
  `JLSR_ASSERT_NOW(a_ready_with_result, $rose(m_tvalid), s_tready)
  `JLSR_ASSERT_NEXT(a_no_result_early, s_tvalid && s_tready, !$rose(m_tvalid))

endmodule

bind jerk_limited_speed_ramp_unit jlsr_chk u_jlsr_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import jlsr_pkg::*;

  typedef struct packed {
    logic [23:0] target;
    logic        restart;
  } tick_t;

  typedef struct packed {
    logic [31:0] accel;
    logic [23:0] speed;
  } ramp_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;

  jerk_limited_speed_ramp_unit uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Predictor state and configuration.
  longint unsigned lim_up, lim_down, rise_cfg, rate_cfg;
  longint          spd_now, acc_now;

  tick_t tick_q[$];
  ramp_t ramp_q[$];
  int    errors;
  bit    calm;
  bit    s_fire;
  int    s_gap, m_gap;
  int    idle_cycles;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic predict_ramp(input tick_t t);
    longint tgt, gap, want, dv, nxt;
    longint unsigned rise, rate, alim, jerk, stp, mag;
    bit up;
    ramp_t r;
    tgt = longint'($signed(t.target));
    rise = (rise_cfg == 0) ? 1 : rise_cfg;
    rate = (rate_cfg == 0) ? 1 : rate_cfg;
    if (t.restart) begin
      spd_now = 0;
      acc_now = 0;
    end
    gap = tgt - spd_now;
    up = (gap >= 0);
    alim = up ? lim_up : lim_down;
    mag = up ? gap : -gap;
    jerk = (alim * rate) / rise;
    stp = alim / rise;
    if (mag != 0 && jerk > 64'hFFFF_FFFF_FFFF_FFFF / (2 * mag)) want = alim;
    else if (2 * jerk * mag >= alim * alim) want = alim;
    else want = int_sqrt(2 * jerk * mag);
    if (!up) want = -want;
    if (acc_now < want) begin
      acc_now += stp;
      if (acc_now > want) acc_now = want;
    end else if (acc_now > want) begin
      acc_now -= stp;
      if (acc_now < want) acc_now = want;
    end
    if (acc_now >= 0) dv = (acc_now + rate / 2) / rate;
    else dv = -((-acc_now + rate / 2) / rate);
    nxt = spd_now + dv;
    if (nxt > 8388607) nxt = 8388607;
    if (nxt < -8388608) nxt = -8388608;
    spd_now = nxt;
    if ((up && spd_now > tgt) || (!up && spd_now < tgt)) begin
      spd_now = tgt;
      acc_now = 0;
    end
    r.speed = spd_now[23:0];
    r.accel = acc_now[31:0];
    ramp_q.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Driver: presents the oldest pending tick and drives the output ready, both with random gaps.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
      s_gap <= 0;
    end else begin
      if (s_tvalid && !s_fire) begin
        // A presented tick stays on the bus until its transfer.
      end else if (s_gap > 0) begin
        s_gap <= s_gap - 1;
        s_tvalid <= 0;
      end else if (tick_q.size() != 0) begin
        s_tvalid <= 1;
        s_tdata <= tick_q[0].target;
        s_tuser <= tick_q[0].restart;
        if (!calm && $urandom_range(0, 9) == 0) s_gap <= $urandom_range(1, 19);
      end else begin
        s_tvalid <= 0;
      end
      if (m_gap > 0) begin
        m_gap <= m_gap - 1;
        m_tready <= 0;
      end else begin
        m_tready <= 1;
        if (!calm && $urandom_range(0, 9) == 0) m_gap <= $urandom_range(1, 19);
      end
    end
  end

  // Monitor: predicts on each input transfer and checks each output transfer.
  always @(posedge clk) begin
    ramp_t got, want;
    if (rst) begin
      s_fire <= 0;
    end else begin
      s_fire <= s_tvalid && s_tready;
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (s_tvalid && s_tready) begin
        predict_ramp(tick_q.pop_front());
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (ramp_q.size() == 0) begin
          report_mismatch("unexpected result", got.speed, 0);
        end else begin
          want = ramp_q.pop_front();
          if (got.speed !== want.speed) report_mismatch("speed_out", got.speed, want.speed);
          if (got.accel !== want.accel) report_mismatch("accel_out", got.accel, want.accel);
        end
      end
      if (idle_cycles > 20000) begin
        $display("[jerk_limited_speed_ramp_unit] ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      REG_ACCEL_LIMIT:  lim_up = val;
      REG_DECEL_LIMIT:  lim_down = val;
      REG_RISE_TICKS:   rise_cfg = val[15:0];
      default:          rate_cfg = val[15:0];
    endcase
  endtask

  task automatic drain();
    wait (tick_q.size() == 0 && ramp_q.size() == 0);
    repeat (150) @(posedge clk);
  endtask

  task automatic push_tick(input logic [23:0] tgt, input logic rs);
    tick_t t;
    t.target = tgt;
    t.restart = rs;
    tick_q.push_back(t);
  endtask

  // Mostly ramps toward a held target, with occasional jumps and restarts.
  task automatic random_run(input int n);
    logic [23:0] tgt;
    int hold;
    hold = 0;
    tgt = 0;
    for (int i = 0; i < n; i++) begin
      if (hold == 0) begin
        case ($urandom_range(0, 3))
          0: tgt = 24'($urandom);
          1: tgt = 24'($urandom_range(0, 4000) - 2000);
          2: tgt = 24'($urandom_range(0, 200000) - 100000);
          default: tgt = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
        endcase
        hold = $urandom_range(1, 40);
      end
      hold--;
      push_tick(tgt, $urandom_range(0, 30) == 0);
    end
  endtask

  initial begin
    errors = 0;
    calm = 0;
    idle_cycles = 0;
    rst = 1;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    s_tvalid = 0;
    s_tdata = 0;
    s_tuser = 0;
    m_tready = 0;
    s_gap = 0;
    m_gap = 0;
    lim_up = 76800;
    lim_down = 76800;
    rise_cfg = 100;
    rate_cfg = 1000;
    spd_now = 0;
    acc_now = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: field extremes, zero gap, restart, both directions.
    push_tick(24'h000000, 0);
    push_tick(24'h7FFFFF, 0);
    push_tick(24'h7FFFFF, 0);
    push_tick(24'h800000, 0);
    push_tick(24'h800000, 1);
    push_tick(24'hFFFFFF, 1);
    push_tick(24'h000001, 0);
    push_tick(24'h000000, 0);
    push_tick(24'h000000, 1);
    // Hold the sender until everything has come back.
    drain();

    // Extremes of the limits, zero rise and rate (treated as one).
    write_reg(REG_ACCEL_LIMIT, 24'hFFFFFF);
    write_reg(REG_DECEL_LIMIT, 24'h000000);
    write_reg(REG_RISE_TICKS, 24'h000000);
    write_reg(REG_TICK_RATE_HZ, 24'h000000);
    push_tick(24'h7FFFFF, 1);
    push_tick(24'h7FFFFF, 0);
    push_tick(24'h800000, 0);
    push_tick(24'h123456, 0);
    drain();
    write_reg(REG_ACCEL_LIMIT, 24'h000001);
    write_reg(REG_DECEL_LIMIT, 24'hFFFFFF);
    write_reg(REG_RISE_TICKS, 24'h00FFFF);
    write_reg(REG_TICK_RATE_HZ, 24'h00FFFF);
    push_tick(24'h800000, 0);
    push_tick(24'h800000, 0);
    push_tick(24'h000100, 1);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_ACCEL_LIMIT, (ph == 5) ? 24'd76800 : 24'($urandom));
      write_reg(REG_DECEL_LIMIT, (ph == 5) ? 24'd76800 : 24'($urandom_range(1, 2000000)));
      write_reg(REG_RISE_TICKS, (ph == 5) ? 24'd100 : 24'($urandom_range(0, 400)));
      write_reg(REG_TICK_RATE_HZ, (ph == 5) ? 24'd1000 : 24'($urandom_range(0, 65535)));
      if (ph == 5) calm = 1;
      random_run(255);
      drain();
    end

    if (errors == 0) begin
      $display("[jerk_limited_speed_ramp_unit] OK");
    end else begin
      $display("[jerk_limited_speed_ramp_unit] ERROR");
    end
    $finish;
  end
endmodule
